[design/bsh_pkg.sv]
// Shared types, constants and the mix round of the lookup2 byte-stream hash.
package bsh_pkg;

   localparam int BLOCK_BYTES = 12;
   localparam int FILL_W      = 4;
   localparam int HASH_W      = 32;
   localparam int TSIZE_W     = 17;
   localparam int BUCKET_W    = 16;
   localparam int MIX_STEPS   = 9;
   localparam int MIX_CNT_W   = 4;
   localparam int DIV_CNT_W   = 5;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [HASH_W-1:0]  GOLDEN    = 32'h9e37_79b9;
   localparam logic [TSIZE_W-1:0] MAX_TABLE = 17'h1_0000;
   localparam logic [TSIZE_W-1:0] TSIZE_RST = 17'd1024;

   localparam logic CSR_SEED       = 1'b0;
   localparam logic CSR_TABLE_SIZE = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       key_end;
   } req_word_type;

   typedef struct packed {
      logic [HASH_W-1:0]   hash_value;
      logic [BUCKET_W-1:0] bucket;
   } rsp_word_type;

   typedef struct packed {
      logic                 accept;
      logic                 block_add;
      logic                 tail_add;
      logic                 mix_step;
      logic [MIX_CNT_W-1:0] mix_index;
      logic                 div_init;
      logic                 div_step;
      logic                 out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic fill_last;
      logic out_free;
   } dp_status_type;

   typedef struct packed {
      logic [HASH_W-1:0] a;
      logic [HASH_W-1:0] b;
      logic [HASH_W-1:0] c;
   } mix_type;

   function automatic mix_type mix_round(mix_type m, logic [MIX_CNT_W-1:0] k);
      mix_type r;
      r = m;
      case (k)
         4'd0: r.a = (m.a - m.b - m.c) ^ (m.c >> 13);
         4'd1: r.b = (m.b - m.c - m.a) ^ (m.a << 8);
         4'd2: r.c = (m.c - m.a - m.b) ^ (m.b >> 13);
         4'd3: r.a = (m.a - m.b - m.c) ^ (m.c >> 12);
         4'd4: r.b = (m.b - m.c - m.a) ^ (m.a << 16);
         4'd5: r.c = (m.c - m.a - m.b) ^ (m.b >> 5);
         4'd6: r.a = (m.a - m.b - m.c) ^ (m.c >> 3);
         4'd7: r.b = (m.b - m.c - m.a) ^ (m.a << 10);
         4'd8: r.c = (m.c - m.a - m.b) ^ (m.b >> 15);
         default: r = m;
      endcase
      return r;
   endfunction

endpackage

[design/byte_stream_hash_bucket_top.sv]
// Top level of the lookup2 byte-stream hash with bucket output.
// Each req word brings one key byte (or an empty end mark). A byte that
// completes a 12-byte block is followed by a block add and one mix row per
// cycle over the 9-row mix unit. The key-end word is followed by a tail add,
// the 9 mix rows, a divider load, the bit-serial remainder unit over every
// hash bit and a result step; a key end that closes a block mixes it first.
// Bucket is the hash modulo table_size (sizes above 65536 act as 65536,
// size 0 gives 0). The result sits in an output register, so the next key
// can start while it waits for rsp_ready. Seed and table size live at byte
// addresses 0 and 4.
module byte_stream_hash_bucket_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  bsh_pkg::req_word_type          req_word,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output bsh_pkg::rsp_word_type          rsp_word,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [bsh_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bsh_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bsh_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import bsh_pkg::*;

   logic [HASH_W-1:0]  seed;
   logic [TSIZE_W-1:0] table_size;
   dp_cmd_type         cmd;
   dp_status_type      status;

   bsh_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .seed       (seed),
      .table_size (table_size)
   );

   bsh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .status    (status),
      .cmd       (cmd)
   );

   bsh_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_word),
      .seed       (seed),
      .table_size (table_size),
      .cmd        (cmd),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

endmodule

[design/bsh_csr.sv]
// APB register file holding the seed and table size.
module bsh_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bsh_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bsh_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bsh_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready,
   output logic [bsh_pkg::HASH_W-1:0]     seed,
   output logic [bsh_pkg::TSIZE_W-1:0]    table_size
);
   import bsh_pkg::*;

   logic [HASH_W-1:0]  seed_ff, seed_in;
   logic [TSIZE_W-1:0] tsize_ff, tsize_in;
   logic               wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      seed_in  = seed_ff;
      tsize_in = tsize_ff;
      if (wr_en) begin
         case (paddr[2])
            CSR_SEED:       seed_in  = pwdata;
            CSR_TABLE_SIZE: tsize_in = pwdata[TSIZE_W-1:0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= GOLDEN;
         tsize_ff <= TSIZE_RST;
      end else begin
         seed_ff  <= seed_in;
         tsize_ff <= tsize_in;
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_SEED:       prdata = seed_ff;
         CSR_TABLE_SIZE: prdata = {{(CSR_DATA_W-TSIZE_W){1'b0}}, tsize_ff};
         default:        prdata = '0;
      endcase
   end

   assign seed       = seed_ff;
   assign table_size = tsize_ff;

endmodule

[design/bsh_ctrl.sv]
// Sequencer for byte intake, block mix, tail add, final mix and bucket division.
module bsh_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bsh_pkg::req_word_type  req_word,
   input  bsh_pkg::dp_status_type status,
   output bsh_pkg::dp_cmd_type    cmd
);
   import bsh_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_BLOCK   = 7'b0000010,
      ST_MIX     = 7'b0000100,
      ST_TAIL    = 7'b0001000,
      ST_MODINIT = 7'b0010000,
      ST_DIV     = 7'b0100000,
      ST_DONE    = 7'b1000000
   } state_type;

   localparam logic [MIX_CNT_W-1:0] MIX_LAST = MIX_CNT_W'(MIX_STEPS - 1);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(HASH_W - 1);

   state_type            state_ff, state_in;
   logic [MIX_CNT_W-1:0] mix_cnt_ff, mix_cnt_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 last_ff, last_in;
   logic                 final_ff, final_in;
   logic                 take;

   assign req_ready = (state_ff == ST_IDLE);
   assign take      = req_valid && req_ready && (req_word.byte_present || req_word.key_end);

   always_comb begin
      state_in   = state_ff;
      mix_cnt_in = mix_cnt_ff;
      div_cnt_in = div_cnt_ff;
      last_in    = last_ff;
      final_in   = final_ff;
      cmd        = '0;
      cmd.mix_index = mix_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               cmd.accept = 1'b1;
               last_in    = req_word.key_end;
               final_in   = 1'b0;
               if (req_word.byte_present && status.fill_last) begin
                  state_in = ST_BLOCK;
               end else if (req_word.key_end) begin
                  state_in = ST_TAIL;
               end
            end
         end
         ST_BLOCK: begin
            cmd.block_add = 1'b1;
            mix_cnt_in    = '0;
            state_in      = ST_MIX;
         end
         ST_MIX: begin
            cmd.mix_step = 1'b1;
            if (mix_cnt_ff == MIX_LAST) begin
               mix_cnt_in = '0;
               if (final_ff) begin
                  state_in = ST_MODINIT;
               end else if (last_ff) begin
                  state_in = ST_TAIL;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               mix_cnt_in = mix_cnt_ff + 1'b1;
            end
         end
         ST_TAIL: begin
            cmd.tail_add = 1'b1;
            final_in     = 1'b1;
            mix_cnt_in   = '0;
            state_in     = ST_MIX;
         end
         ST_MODINIT: begin
            cmd.div_init = 1'b1;
            div_cnt_in   = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_DONE;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               final_in     = 1'b0;
               last_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         mix_cnt_ff <= '0;
         div_cnt_ff <= '0;
         last_ff    <= 1'b0;
         final_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         mix_cnt_ff <= mix_cnt_in;
         div_cnt_ff <= div_cnt_in;
         last_ff    <= last_in;
         final_ff   <= final_in;
      end
   end

   a_key_end_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_word.key_end |=> !req_ready)
      else $error("key end word did not start hashing");

   a_mix_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MIX |-> mix_cnt_ff <= MIX_LAST)
      else $error("mix step count out of range");

   a_final_tail: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MODINIT |-> final_ff && last_ff)
      else $error("division started without tail mix");

endmodule

[design/bsh_dp.sv]
// Datapath: block buffer, mix registers, bucket divider and result register.
module bsh_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  bsh_pkg::req_word_type       req_word,
   input  logic [bsh_pkg::HASH_W-1:0]  seed,
   input  logic [bsh_pkg::TSIZE_W-1:0] table_size,
   input  bsh_pkg::dp_cmd_type         cmd,
   output bsh_pkg::dp_status_type      status,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output bsh_pkg::rsp_word_type       rsp_word
);
   import bsh_pkg::*;

   mix_type              mix_ff, mix_in;
   logic [7:0]           bytes_ff [BLOCK_BYTES];
   logic [7:0]           tail_bytes [BLOCK_BYTES];
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [HASH_W-1:0]    len_ff, len_in;
   logic [HASH_W-1:0]    quo_ff, quo_in;
   logic [TSIZE_W-1:0]   rem_ff, rem_in;
   logic [TSIZE_W-1:0]   size_ff, size_in;
   logic [TSIZE_W:0]     trial;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_word_ff, rsp_word_in;
   logic                 key_start;

   assign key_start = (len_ff == '0) && (fill_ff == '0);
   assign trial     = {rem_ff, quo_ff[HASH_W-1]};

   always_comb begin
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         tail_bytes[i] = (FILL_W'(i) < fill_ff && i < BLOCK_BYTES - 1) ? bytes_ff[i] : 8'h00;
      end
   end

   always_comb begin
      mix_in       = mix_ff;
      fill_in      = fill_ff;
      len_in       = len_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      size_in      = size_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (cmd.accept) begin
         if (key_start) begin
            mix_in.a = GOLDEN;
            mix_in.b = GOLDEN;
            mix_in.c = seed;
         end
         if (req_word.byte_present) begin
            fill_in = fill_ff + 1'b1;
            len_in  = len_ff + 1'b1;
         end
      end
      if (cmd.block_add) begin
         mix_in.a = mix_ff.a + {bytes_ff[3], bytes_ff[2], bytes_ff[1], bytes_ff[0]};
         mix_in.b = mix_ff.b + {bytes_ff[7], bytes_ff[6], bytes_ff[5], bytes_ff[4]};
         mix_in.c = mix_ff.c + {bytes_ff[11], bytes_ff[10], bytes_ff[9], bytes_ff[8]};
         fill_in  = '0;
      end
      if (cmd.tail_add) begin
         mix_in.a = mix_ff.a
                  + {tail_bytes[3], tail_bytes[2], tail_bytes[1], tail_bytes[0]};
         mix_in.b = mix_ff.b
                  + {tail_bytes[7], tail_bytes[6], tail_bytes[5], tail_bytes[4]};
         mix_in.c = mix_ff.c + len_ff
                  + {tail_bytes[10], tail_bytes[9], tail_bytes[8], 8'h00};
         fill_in  = '0;
         len_in   = '0;
      end
      if (cmd.mix_step) begin
         mix_in = mix_round(mix_ff, cmd.mix_index);
      end
      if (cmd.div_init) begin
         quo_in  = mix_ff.c;
         rem_in  = '0;
         size_in = (table_size > MAX_TABLE) ? MAX_TABLE : table_size;
      end
      if (cmd.div_step) begin
         quo_in = {quo_ff[HASH_W-2:0], 1'b0};
         if (trial >= {1'b0, size_ff}) begin
            rem_in = TSIZE_W'(trial - {1'b0, size_ff});
         end else begin
            rem_in = trial[TSIZE_W-1:0];
         end
      end
      if (cmd.out_load) begin
         rsp_valid_in           = 1'b1;
         rsp_word_in.hash_value = mix_ff.c;
         rsp_word_in.bucket     = (size_ff == '0) ? '0 : rem_ff[BUCKET_W-1:0];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mix_ff      <= mix_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      size_ff     <= size_in;
      rsp_word_ff <= rsp_word_in;
      if (cmd.accept && req_word.byte_present) begin
         bytes_ff[fill_ff] <= req_word.data_byte;
      end
   end

   assign status.fill_last = (fill_ff == FILL_W'(BLOCK_BYTES - 1));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_word         = rsp_word_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff == FILL_W'(BLOCK_BYTES) |-> cmd.block_add)
      else $error("full block not mixed");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rsp_valid_ff || rsp_ready)
      else $error("pending result overwritten");

endmodule

[verif/byte_stream_hash_bucket_top_tb.sv]
// Self-checking testbench for the lookup2 byte-stream hash with bucket output.
`timescale 1ns / 100ps

module byte_stream_hash_bucket_top_tb;
   import bsh_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned SETTLE_COUNT = 64;
   localparam int unsigned HOLD_COUNT   = 500;
   localparam int unsigned RANDOM_WORDS = 300;

   localparam logic [CSR_ADDR_W-1:0] SEED_ADDR  = CSR_ADDR_W'(4 * CSR_SEED);
   localparam logic [CSR_ADDR_W-1:0] TSIZE_ADDR = CSR_ADDR_W'(4 * CSR_TABLE_SIZE);

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_word_type          req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_word_type          rsp_word;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   logic [HASH_W-1:0]  hash_seed  = GOLDEN;
   logic [TSIZE_W-1:0] table_size = TSIZE_RST;
   logic [HASH_W-1:0]  state_a    = GOLDEN;
   logic [HASH_W-1:0]  state_b    = GOLDEN;
   logic [HASH_W-1:0]  state_c    = GOLDEN;
   logic [7:0]         pend_bytes [BLOCK_BYTES];
   int unsigned        pend_fill  = 0;
   logic [31:0]        key_bytes  = '0;
   rsp_word_type       hash_queue [$];

   int unsigned fail_count  = 0;
   int unsigned words_sent  = 0;
   int unsigned cycle_count = 0;
   int unsigned rsp_stall   = 0;
   int unsigned hold_left   = 0;
   logic        hold_req    = 1'b0;
   logic        hold_done   = 1'b0;
   logic        quiet       = 1'b0;

   byte_stream_hash_bucket_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void lookup2_mix(inout logic [31:0] a, inout logic [31:0] b,
                                       inout logic [31:0] c);
      a = (a - b - c) ^ (c >> 13);
      b = (b - c - a) ^ (a << 8);
      c = (c - a - b) ^ (b >> 13);
      a = (a - b - c) ^ (c >> 12);
      b = (b - c - a) ^ (a << 16);
      c = (c - a - b) ^ (b >> 5);
      a = (a - b - c) ^ (c >> 3);
      b = (b - c - a) ^ (a << 10);
      c = (c - a - b) ^ (b >> 15);
   endfunction

   function automatic void hash_word(req_word_type w);
      rsp_word_type r;
      logic [31:0]  size;
      logic [31:0]  v;
      if (!w.byte_present && !w.key_end) return;
      if (key_bytes == 0 && pend_fill == 0) begin
         state_a = GOLDEN;
         state_b = GOLDEN;
         state_c = hash_seed;
      end
      if (w.byte_present) begin
         pend_bytes[pend_fill] = w.data_byte;
         pend_fill++;
         key_bytes++;
         if (pend_fill == BLOCK_BYTES) begin
            state_a += {pend_bytes[3], pend_bytes[2], pend_bytes[1], pend_bytes[0]};
            state_b += {pend_bytes[7], pend_bytes[6], pend_bytes[5], pend_bytes[4]};
            state_c += {pend_bytes[11], pend_bytes[10], pend_bytes[9], pend_bytes[8]};
            lookup2_mix(state_a, state_b, state_c);
            pend_fill = 0;
         end
      end
      if (!w.key_end) return;
      state_c += key_bytes;
      for (int unsigned i = 0; i < pend_fill; i++) begin
         v = 32'(pend_bytes[i]);
         if (i < 4)      state_a += v << (8 * i);
         else if (i < 8) state_b += v << (8 * (i - 4));
         else            state_c += v << (8 * (i - 8) + 8);
      end
      lookup2_mix(state_a, state_b, state_c);
      size = (table_size > MAX_TABLE) ? 32'(MAX_TABLE) : 32'(table_size);
      r.hash_value = state_c;
      r.bucket     = (size == 0) ? '0 : BUCKET_W'(state_c % size);
      hash_queue.push_back(r);
      pend_fill = 0;
      key_bytes = '0;
   endfunction

   task automatic send_word(input logic [7:0] b, input logic present, input logic last);
      req_word_type w;
      int unsigned  gap;
      w.data_byte    = b;
      w.byte_present = present;
      w.key_end      = last;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      if (present || last) words_sent++;
      hash_word(w);
   endtask

   task automatic send_random_key(input int unsigned len);
      logic on_byte;
      on_byte = 1'($urandom_range(0, 1));
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) send_word(8'($urandom), 1'b0, 1'b0);
         send_word(8'($urandom), 1'b1, on_byte && (i == len - 1));
      end
      if (len == 0 || !on_byte) send_word(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == SEED_ADDR) hash_seed = data;
      else if (addr == TSIZE_ADDR) table_size = data[TSIZE_W-1:0];
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (hash_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_COUNT) @(posedge clock);
   endtask

   task automatic test_reset_config();
      send_word(8'h5a, 1'b0, 1'b1);
      send_word(8'hff, 1'b1, 1'b1);
      send_word(8'hff, 1'b0, 1'b0);
      send_word(8'h00, 1'b1, 1'b0);
      send_word(8'hff, 1'b0, 1'b0);
      send_word(8'h00, 1'b0, 1'b1);
      wait_idle();
   endtask

   task automatic test_block_boundary();
      for (int unsigned i = 0; i < BLOCK_BYTES; i++)
         send_word(i[0] ? 8'h00 : 8'hff, 1'b1, i == BLOCK_BYTES - 1);
      wait_idle();
   endtask

   task automatic test_table_limits();
      csr_write(SEED_ADDR, 32'h0000_0000);
      csr_write(TSIZE_ADDR, 32'd0);
      send_word(8'h01, 1'b1, 1'b0);
      send_word(8'h80, 1'b1, 1'b0);
      send_word(8'hfe, 1'b1, 1'b1);
      wait_idle();
      csr_write(TSIZE_ADDR, 32'h0001_ffff);
      send_word(8'h7f, 1'b1, 1'b0);
      send_word(8'hc3, 1'b1, 1'b1);
      wait_idle();
      csr_write(TSIZE_ADDR, 32'd1);
      send_word(8'h3c, 1'b1, 1'b1);
      wait_idle();
      csr_write(SEED_ADDR, 32'hffff_ffff);
      csr_write(TSIZE_ADDR, 32'd65536);
      send_word(8'hff, 1'b1, 1'b1);
      wait_idle();
   endtask

   task automatic test_seed_mid_key();
      csr_write(SEED_ADDR, $urandom);
      csr_write(TSIZE_ADDR, $urandom_range(1, 65536));
      for (int unsigned i = 0; i < 3; i++) send_word(8'($urandom), 1'b1, 1'b0);
      wait_idle();
      csr_write(SEED_ADDR, $urandom);
      for (int unsigned i = 0; i < 10; i++) send_word(8'($urandom), 1'b1, i == 9);
      send_random_key(4);
      wait_idle();
   endtask

   task automatic test_output_backpressure();
      quiet    = 1'b1;
      hold_req <= 1'b1;
      for (int unsigned k = 0; k < 20; k++) send_random_key($urandom_range(0, 3));
      quiet = 1'b0;
      wait_idle();
   endtask

   task automatic test_random_traffic();
      int unsigned target;
      int unsigned len;
      for (int unsigned p = 0; p < 5; p++) begin
         case (p)
            0: begin
               csr_write(SEED_ADDR, $urandom);
               csr_write(TSIZE_ADDR, $urandom_range(1, 65536));
            end
            1: begin
               csr_write(SEED_ADDR, 32'h0000_0000);
               csr_write(TSIZE_ADDR, 32'd1);
            end
            2: begin
               csr_write(SEED_ADDR, 32'hffff_ffff);
               csr_write(TSIZE_ADDR, 32'd65536);
            end
            3: begin
               csr_write(SEED_ADDR, $urandom);
               csr_write(TSIZE_ADDR, $urandom_range(65537, 131071));
            end
            default: begin
               csr_write(SEED_ADDR, $urandom);
               csr_write(TSIZE_ADDR, $urandom_range(0, 1000));
            end
         endcase
         quiet  = (p == 2);
         target = words_sent + RANDOM_WORDS / 5;
         while (words_sent < target) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40)
                                              : $urandom_range(0, 14);
            send_random_key(len);
         end
         wait_idle();
      end
      quiet = 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_done <= 1'b1;
         hold_left <= HOLD_COUNT;
      end else if (rsp_stall != 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= pick_gap();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_word_type exp_word;
      if (!reset && rsp_valid && rsp_ready) begin
         if (hash_queue.size() == 0) begin
            $display("%0t: unexpected result word hash_value %h bucket %h",
                     $time, rsp_word.hash_value, rsp_word.bucket);
            fail_count++;
         end else begin
            exp_word = hash_queue.pop_front();
            if (rsp_word.hash_value !== exp_word.hash_value) begin
               $display("%0t: hash_value mismatch: expected %h actual %h",
                        $time, exp_word.hash_value, rsp_word.hash_value);
               fail_count++;
            end
            if (rsp_word.bucket !== exp_word.bucket) begin
               $display("%0t: bucket mismatch: expected %h actual %h",
                        $time, exp_word.bucket, rsp_word.bucket);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("byte_stream_hash_bucket_top verification failed");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_config();
      test_block_boundary();
      test_table_limits();
      test_seed_mid_key();
      test_output_backpressure();
      test_random_traffic();
      if (hash_queue.size() != 0) begin
         $display("%0t: %0d result words never arrived", $time, hash_queue.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("byte_stream_hash_bucket_top verification clean");
      else
         $display("byte_stream_hash_bucket_top verification failed");
      $finish;
   end

endmodule

[files.f]
design/bsh_pkg.sv
design/bsh_csr.sv
design/bsh_ctrl.sv
design/bsh_dp.sv
design/byte_stream_hash_bucket_top.sv
verif/byte_stream_hash_bucket_top_tb.sv
